// ----- hw/rtl/ubf_pkg.sv -----
`timescale 1ns / 1ps

package ubf_pkg;

    // Default FIFO depths
    localparam int DEF_TX_DEPTH = 16;
    localparam int DEF_RX_DEPTH = 16;

    localparam int DATA_W = 8;

    // Item operations
    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_LINE_RX = 2'd2,
        OP_TX_TAKE = 2'd3
    } op_t;

    // Register offsets
    localparam logic [2:0] OFS_DATA = 3'd0;
    localparam logic [2:0] OFS_IER  = 3'd1;
    localparam logic [2:0] OFS_FCR  = 3'd2;
    localparam logic [2:0] OFS_LCR  = 3'd3;
    localparam logic [2:0] OFS_MCR  = 3'd4;
    localparam logic [2:0] OFS_LSR  = 3'd5;
    localparam logic [2:0] OFS_MSR  = 3'd6;
    localparam logic [2:0] OFS_SCR  = 3'd7;

    // Bit positions and masks
    localparam int LCR_DLAB_BIT   = 7;
    localparam int FCR_RX_RST_BIT = 1;
    localparam int FCR_TX_RST_BIT = 2;
    localparam int IER_RX_BIT     = 0;
    localparam int IER_TX_BIT     = 1;
    localparam int LSR_DR_BIT     = 0;
    localparam int LSR_THRE_BIT   = 5;

    localparam logic [7:0] LS_DR    = 8'h01;
    localparam logic [7:0] LS_OE    = 8'h02;
    localparam logic [7:0] LS_THRE  = 8'h20;
    localparam logic [7:0] LS_EMPTY = 8'h60;
    localparam logic [7:0] LS_RESET = 8'h60;

    localparam logic [4:0] MCR_RESET = 5'h08;
    localparam logic [7:0] MSR_VALUE = 8'hB0;
    localparam logic [7:0] IIR_RX    = 8'h04;
    localparam logic [7:0] IIR_NONE  = 8'h01;

    // FIFO control and status
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } fifo_stat_t;

    // Per-item result, resolved against FIFO read data at the output
    typedef struct packed {
        logic [DATA_W-1:0] rd_value;
        logic              rx_pop;
        logic              tx_pop;
        logic              irq;
    } result_t;

endpackage

// ----- hw/rtl/uart_register_block_with_fifos.sv -----
`timescale 1ns / 1ps

// 16550-style UART register block with receive and transmit byte FIFOs.
// Each input item is a bus read, a bus write, a received line byte or a
// transmitter take; each produces exactly one result item. One item is
// accepted per clock and its result appears the next cycle: the register
// file and FIFO pointers update at acceptance, and the popped byte comes from
// the FIFO's registered read port into the result. in_ready stays high while
// the result register is empty or being drained, so the block sustains one
// item per cycle. No clearing pass is needed after reset.
module uart_register_block_with_fifos
    import ubf_pkg::*;
#(
    parameter int TX_DEPTH = DEF_TX_DEPTH,
    parameter int RX_DEPTH = DEF_RX_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [2:0]  reg_offset,
    input  logic [7:0]  write_data,
    input  logic [7:0]  line_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        irq_level
);

    logic       accept;
    logic       out_valid_reg;
    result_t    res;
    result_t    res_reg;
    fifo_ctrl_t rx_ctrl;
    fifo_ctrl_t tx_ctrl;
    fifo_stat_t rx_stat;
    fifo_stat_t tx_stat;
    logic [7:0] rx_rdata;
    logic [7:0] tx_rdata;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    ubf_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op_t'(opcode)),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .rx_stat    (rx_stat),
        .tx_stat    (tx_stat),
        .rx_ctrl    (rx_ctrl),
        .tx_ctrl    (tx_ctrl),
        .res        (res)
    );

    ubf_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rx_ctrl),
        .wdata (line_byte),
        .rdata (rx_rdata),
        .stat  (rx_stat)
    );

    ubf_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tx_ctrl),
        .wdata (write_data),
        .rdata (tx_rdata),
        .stat  (tx_stat)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Result payload; FIFO read data is registered alongside it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    // Output fields
    assign out_valid = out_valid_reg;
    assign read_data = res_reg.rx_pop ? rx_rdata : res_reg.rd_value;
    assign tx_byte   = res_reg.tx_pop ? tx_rdata : 8'h00;
    assign tx_valid  = res_reg.tx_pop;
    assign irq_level = res_reg.irq;

endmodule

// ----- hw/rtl/ubf_fifo.sv -----
`timescale 1ns / 1ps

module ubf_fifo
    import ubf_pkg::*;
#(
    parameter int DEPTH = DEF_RX_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata,
    output fifo_stat_t        stat
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FILL_FULL);
    assign stat.last  = (fill_reg == FILL_ONE);
    assign rdata      = rdata_reg;

    // Pointer and fill update; a push into a full FIFO drops the oldest item
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        priority if (ctrl.clear)
        begin
            wptr_next = '0;
            rptr_next = '0;
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            wptr_next = ptr_inc(wptr_reg);
            if (stat.full)
            begin
                rptr_next = ptr_inc(rptr_reg);
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        else if (ctrl.pop)
        begin
            rptr_next = ptr_inc(rptr_reg);
            fill_next = fill_reg - FILL_W'(1);
        end
        else
        begin
            // idle: pointers and fill hold
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wptr_reg] <= wdata;
        end
        if (ctrl.pop)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

endmodule

// ----- hw/rtl/ubf_regs.sv -----
`timescale 1ns / 1ps

module ubf_regs
    import ubf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  op_t               op,
    input  logic [2:0]        reg_offset,
    input  logic [DATA_W-1:0] write_data,
    input  fifo_stat_t        rx_stat,
    input  fifo_stat_t        tx_stat,
    output fifo_ctrl_t        rx_ctrl,
    output fifo_ctrl_t        tx_ctrl,
    output result_t           res
);

    logic [3:0] ier_reg, ier_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [4:0] mcr_reg, mcr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic [7:0] scr_reg, scr_next;
    logic [7:0] lsr_reg, lsr_next;

    fifo_ctrl_t rx_c;
    fifo_ctrl_t tx_c;
    logic       dlab;
    logic       rx_ne;
    logic [7:0] oe_keep;
    logic [7:0] dr_now;
    logic [7:0] empty_now;

    assign dlab      = lcr_reg[LCR_DLAB_BIT];
    assign rx_ne     = !rx_stat.empty;
    assign oe_keep   = lsr_reg & LS_OE;
    assign dr_now    = rx_ne ? LS_DR : 8'h00;
    assign empty_now = tx_stat.empty ? LS_EMPTY : 8'h00;

    // FIFO commands only fire on an accepted item
    assign rx_ctrl = accept ? rx_c : '0;
    assign tx_ctrl = accept ? tx_c : '0;

    // Register file decode and line status update
    always_comb
    begin
        ier_next = ier_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        scr_next = scr_reg;
        lsr_next = lsr_reg;
        rx_c     = '0;
        tx_c     = '0;
        res      = '0;

        unique case (op)
            OP_READ:
            begin
                unique case (reg_offset)
                    OFS_DATA:
                    begin
                        if (dlab)
                        begin
                            res.rd_value = dll_reg;
                        end
                        else if (rx_ne)
                        begin
                            rx_c.pop   = 1'b1;
                            res.rx_pop = 1'b1;
                            // recompute, overrun cleared
                            lsr_next = (rx_stat.last ? 8'h00 : LS_DR) | empty_now;
                        end
                    end
                    OFS_IER: res.rd_value = dlab ? dlm_reg : {4'b0, ier_reg};
                    OFS_FCR: res.rd_value = (ier_reg[IER_RX_BIT] && rx_ne) ? IIR_RX : IIR_NONE;
                    OFS_LCR: res.rd_value = lcr_reg;
                    OFS_MCR: res.rd_value = {3'b0, mcr_reg};
                    OFS_LSR: res.rd_value = lsr_reg;
                    OFS_MSR: res.rd_value = MSR_VALUE;
                    OFS_SCR: res.rd_value = scr_reg;
                endcase
            end
            OP_WRITE:
            begin
                unique case (reg_offset)
                    OFS_DATA:
                    begin
                        if (dlab)
                        begin
                            dll_next = write_data;
                        end
                        else
                        begin
                            tx_c.push = 1'b1;
                            // THRE forced on after the push
                            lsr_next = oe_keep | (tx_stat.full ? LS_OE : 8'h00)
                                     | dr_now | LS_THRE;
                        end
                    end
                    OFS_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = write_data;
                        end
                        else
                        begin
                            ier_next = write_data[3:0];
                        end
                    end
                    OFS_FCR:
                    begin
                        priority if (write_data[FCR_RX_RST_BIT])
                        begin
                            rx_c.clear = 1'b1;
                            lsr_next   = oe_keep | empty_now;
                        end
                        else if (write_data[FCR_TX_RST_BIT])
                        begin
                            tx_c.clear = 1'b1;
                            lsr_next   = oe_keep | dr_now | LS_EMPTY;
                        end
                        else
                        begin
                            // neither reset bit set: no effect
                        end
                    end
                    OFS_LCR: lcr_next = write_data;
                    OFS_MCR: mcr_next = write_data[4:0];
                    OFS_SCR: scr_next = write_data;
                    default:
                    begin
                        // status registers are read-only
                    end
                endcase
            end
            OP_LINE_RX:
            begin
                rx_c.push = 1'b1;
                lsr_next  = lsr_reg | LS_DR | (rx_stat.full ? LS_OE : 8'h00);
            end
            OP_TX_TAKE:
            begin
                if (!tx_stat.empty)
                begin
                    tx_c.pop   = 1'b1;
                    res.tx_pop = 1'b1;
                    lsr_next   = oe_keep | dr_now | (tx_stat.last ? LS_EMPTY : 8'h00);
                end
            end
        endcase

        // Interrupt level from the updated state
        res.irq = (ier_next[IER_RX_BIT] && lsr_next[LSR_DR_BIT])
               || (ier_next[IER_TX_BIT] && lsr_next[LSR_THRE_BIT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ier_reg <= '0;
            lcr_reg <= '0;
            mcr_reg <= MCR_RESET;
            dll_reg <= '0;
            dlm_reg <= '0;
            scr_reg <= '0;
            lsr_reg <= LS_RESET;
        end
        else if (accept)
        begin
            ier_reg <= ier_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            dll_reg <= dll_next;
            dlm_reg <= dlm_next;
            scr_reg <= scr_next;
            lsr_reg <= lsr_next;
        end
    end

endmodule

// ----- bench/uart_register_block_with_fifos_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the UART register block, keeps a shadow copy of
// the register file and both FIFOs, and compares every result item against
// the oldest prediction.
module uart_register_block_with_fifos_checker
    import ubf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [2:0] reg_offset,
    input  logic [7:0] write_data,
    input  logic [7:0] line_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] read_data,
    input  logic [7:0] tx_byte,
    input  logic       tx_valid,
    input  logic       irq_level,
    output int         mismatch_count,
    output int         pending_count
);

    localparam logic [7:0] IER_MASK = 8'h0F;
    localparam logic [7:0] MCR_MASK = 8'h1F;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] rd;
        logic [7:0] txb;
        logic       txv;
        logic       irq;
    } uart_result_t;

    uart_result_t awaited_results [$];

    // Shadow FIFOs: head is the read side, tail the write side
    logic [7:0] rx_bytes [DEF_RX_DEPTH];
    logic [7:0] tx_bytes [DEF_TX_DEPTH];
    int rx_head, rx_tail, rx_level;
    int tx_head, tx_tail, tx_level;

    // Shadow registers
    logic [7:0] lsr_q, ier_q, lcr_q, mcr_q, dll_q, dlm_q, scr_q;
    logic       irq_q;

    int errors;
    int outstanding;

    assign mismatch_count = errors;
    assign pending_count  = outstanding;

    task reset_shadow();
        rx_head  = 0;
        rx_tail  = 0;
        rx_level = 0;
        tx_head  = 0;
        tx_tail  = 0;
        tx_level = 0;
        lsr_q    = LS_RESET;
        ier_q    = 8'h00;
        lcr_q    = 8'h00;
        mcr_q    = {3'b000, MCR_RESET};
        dll_q    = 8'h00;
        dlm_q    = 8'h00;
        scr_q    = 8'h00;
        irq_q    = 1'b0;
    endtask

    // Line status from FIFO fill levels; overrun is sticky
    task refresh_lsr();
        logic [7:0] s;
        s = lsr_q & LS_OE;
        if (rx_level > 0)
            s = s | LS_DR;
        if (tx_level == 0)
            s = s | LS_EMPTY;
        lsr_q = s;
    endtask

    // Apply one item to the shadow state and return the result it causes
    task step_uart_shadow(input logic [1:0] op, input logic [2:0] ofs,
                          input logic [7:0] wd, input logic [7:0] lb,
                          output uart_result_t r);
        logic dlab;
        logic dropped;
        r = '0;
        dlab = lcr_q[LCR_DLAB_BIT];
        case (op)
            OP_READ:
            begin
                case (ofs)
                    OFS_DATA:
                    begin
                        if (dlab)
                            r.rd = dll_q;
                        else if (rx_level > 0)
                        begin
                            r.rd = rx_bytes[rx_head];
                            rx_head = (rx_head + 1) % DEF_RX_DEPTH;
                            rx_level--;
                            refresh_lsr();
                            lsr_q = lsr_q & ~LS_OE;
                        end
                    end
                    OFS_IER: r.rd = dlab ? dlm_q : ier_q;
                    OFS_FCR: r.rd = (ier_q[IER_RX_BIT] && rx_level > 0) ? IIR_RX : IIR_NONE;
                    OFS_LCR: r.rd = lcr_q;
                    OFS_MCR: r.rd = mcr_q;
                    OFS_LSR: r.rd = lsr_q;
                    OFS_MSR: r.rd = MSR_VALUE;
                    default: r.rd = scr_q;
                endcase
            end
            OP_WRITE:
            begin
                case (ofs)
                    OFS_DATA:
                    begin
                        if (dlab)
                            dll_q = wd;
                        else
                        begin
                            // full FIFO loses its oldest byte
                            dropped = (tx_level >= DEF_TX_DEPTH);
                            if (dropped)
                            begin
                                tx_head = (tx_head + 1) % DEF_TX_DEPTH;
                                tx_level--;
                            end
                            tx_bytes[tx_tail] = wd;
                            tx_tail = (tx_tail + 1) % DEF_TX_DEPTH;
                            tx_level++;
                            refresh_lsr();
                            if (dropped)
                                lsr_q = lsr_q | LS_OE;
                            lsr_q = lsr_q | LS_THRE;
                        end
                    end
                    OFS_IER:
                    begin
                        if (dlab)
                            dlm_q = wd;
                        else
                            ier_q = wd & IER_MASK;
                    end
                    OFS_FCR:
                    begin
                        // receive reset wins over transmit reset
                        if (wd[FCR_RX_RST_BIT])
                        begin
                            rx_head  = 0;
                            rx_tail  = 0;
                            rx_level = 0;
                            refresh_lsr();
                        end
                        else if (wd[FCR_TX_RST_BIT])
                        begin
                            tx_head  = 0;
                            tx_tail  = 0;
                            tx_level = 0;
                            refresh_lsr();
                        end
                    end
                    OFS_LCR: lcr_q = wd;
                    OFS_MCR: mcr_q = wd & MCR_MASK;
                    OFS_SCR: scr_q = wd;
                    default: ;
                endcase
            end
            OP_LINE_RX:
            begin
                if (rx_level >= DEF_RX_DEPTH)
                begin
                    rx_head = (rx_head + 1) % DEF_RX_DEPTH;
                    rx_level--;
                    lsr_q = lsr_q | LS_OE;
                end
                rx_bytes[rx_tail] = lb;
                rx_tail = (rx_tail + 1) % DEF_RX_DEPTH;
                rx_level++;
                lsr_q = lsr_q | LS_DR;
            end
            default:
            begin
                if (tx_level > 0)
                begin
                    r.txb = tx_bytes[tx_head];
                    r.txv = 1'b1;
                    tx_head = (tx_head + 1) % DEF_TX_DEPTH;
                    tx_level--;
                    refresh_lsr();
                end
            end
        endcase
        irq_q = (ier_q[IER_RX_BIT] && lsr_q[LSR_DR_BIT]) ||
                (ier_q[IER_TX_BIT] && lsr_q[LSR_THRE_BIT]);
        r.irq = irq_q;
    endtask

    // Results first (they belong to earlier items), then the new item
    always @(posedge clk or negedge rst_n)
    begin
        uart_result_t want;
        uart_result_t got;
        if (!rst_n)
        begin
            reset_shadow();
            awaited_results.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {read_data, tx_byte, tx_valid, irq_level};
                if (awaited_results.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: result with nothing awaited: rd=%h txb=%h txv=%b irq=%b",
                                 $realtime, got.rd, got.txb, got.txv, got.irq);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.rd !== want.rd || got.txb !== want.txb ||
                        got.txv !== want.txv || got.irq !== want.irq)
                    begin
                        if (errors < REPORT_LIMIT)
                            $display("%0t: mismatch rd=%h/%h txb=%h/%h txv=%b/%b irq=%b/%b (exp/act)",
                                     $realtime, want.rd, got.rd, want.txb, got.txb,
                                     want.txv, got.txv, want.irq, got.irq);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                step_uart_shadow(opcode, reg_offset, write_data, line_byte, want);
                awaited_results.push_back(want);
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

// ----- bench/uart_register_block_with_fifos_test.sv -----
`timescale 1ns / 1ps

module uart_register_block_with_fifos_test;
    import ubf_pkg::*;

    localparam int RANDOM_ITEMS      = 1150;
    localparam int CYCLE_LIMIT       = 300000;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES      = 20;
    localparam int MAX_GAP           = 14;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] opcode;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] line_byte;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       irq_level;

    logic no_idle;
    logic long_stall;
    logic stall_request;
    int   sent_items;
    int   cycle_count;
    int   ready_wait;
    int   mismatch_count;
    int   pending_count;

    uart_register_block_with_fifos dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .line_byte  (line_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .tx_byte    (tx_byte),
        .tx_valid   (tx_valid),
        .irq_level  (irq_level)
    );

    uart_register_block_with_fifos_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .reg_offset     (reg_offset),
        .write_data     (write_data),
        .line_byte      (line_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .tx_byte        (tx_byte),
        .tx_valid       (tx_valid),
        .irq_level      (irq_level),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random wait before each item, plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                ready_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (ready_wait > 0)
            begin
                ready_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !long_stall;
        end
    end

    // Long hold-off of the result side so the block backs up its input
    initial
    begin
        long_stall <= 1'b0;
        wait (stall_request);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall <= 1'b0;
    end

    // Random field values at field width
    function automatic logic [7:0] rand_byte();
        rand_byte = 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] rand_ofs();
        rand_ofs = 3'($urandom_range(0, 7));
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task send_item(input logic [1:0] op, input logic [2:0] ofs,
                   input logic [7:0] wd, input logic [7:0] lb);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        reg_offset <= ofs;
        write_data <= wd;
        line_byte  <= lb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    task send_any();
        send_item(2'($urandom_range(0, 3)), rand_ofs(), rand_byte(), rand_byte());
    endtask

    // Stimulus and verdict
    initial
    begin
        int random_base;
        int kind;
        int run_len;
        int k;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        opcode        <= OP_READ;
        reg_offset    <= OFS_DATA;
        write_data    <= 8'h00;
        line_byte     <= 8'h00;
        no_idle       <= 1'b0;
        stall_request <= 1'b0;
        sent_items  = 0;
        cycle_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of every register, empty receive read included
        for (k = 0; k < 8; k++)
            send_item(OP_READ, k[2:0], 8'h00, 8'h00);
        // Enable mask, divisor latches through DLAB
        send_item(OP_WRITE, OFS_IER, 8'hFF, 8'h00);
        send_item(OP_WRITE, OFS_LCR, 8'h80, 8'h00);
        send_item(OP_WRITE, OFS_DATA, 8'hFF, 8'h00);
        send_item(OP_WRITE, OFS_IER, 8'hA5, 8'h00);
        send_item(OP_READ, OFS_DATA, 8'h00, 8'h00);
        send_item(OP_READ, OFS_IER, 8'h00, 8'h00);
        send_item(OP_WRITE, OFS_LCR, 8'h00, 8'h00);
        // Masked modem control, scratch, ignored status writes
        send_item(OP_WRITE, OFS_MCR, 8'hFF, 8'h00);
        send_item(OP_WRITE, OFS_SCR, 8'hFF, 8'h00);
        send_item(OP_WRITE, OFS_LSR, 8'h00, 8'h00);
        // Receive one byte, see the interrupt id, pop it
        send_item(OP_LINE_RX, OFS_DATA, 8'h00, 8'hFF);
        send_item(OP_READ, OFS_FCR, 8'h00, 8'h00);
        send_item(OP_READ, OFS_DATA, 8'h00, 8'h00);
        // Transmit push keeps THRE set, take it, take from empty
        send_item(OP_WRITE, OFS_DATA, 8'h00, 8'h00);
        send_item(OP_TX_TAKE, OFS_DATA, 8'h00, 8'h00);
        send_item(OP_TX_TAKE, OFS_DATA, 8'h00, 8'h00);
        // Both reset bits: receive reset only; then transmit reset
        send_item(OP_WRITE, OFS_FCR, 8'h06, 8'h00);
        send_item(OP_WRITE, OFS_FCR, 8'h04, 8'h00);

        random_base = sent_items;
        while (sent_items - random_base < RANDOM_ITEMS)
        begin
            no_idle <= ($urandom_range(0, 5) == 0);
            if (sent_items - random_base > 300)
                stall_request <= 1'b1;
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                // noise: any field value
                run_len = $urandom_range(5, 30);
                for (k = 0; k < run_len; k++)
                    send_any();
            end
            else if (kind <= 5)
            begin
                // receive flood, overrun likely, then drain with status reads
                send_item(OP_WRITE, OFS_LCR, rand_byte() & 8'h7F, rand_byte());
                run_len = $urandom_range(4, 24);
                for (k = 0; k < run_len; k++)
                    send_item(OP_LINE_RX, rand_ofs(), rand_byte(), rand_byte());
                run_len = $urandom_range(1, 24);
                for (k = 0; k < run_len; k++)
                    case ($urandom_range(0, 5))
                        0:       send_item(OP_READ, OFS_LSR, rand_byte(), rand_byte());
                        1:       send_item(OP_READ, OFS_FCR, rand_byte(), rand_byte());
                        default: send_item(OP_READ, OFS_DATA, rand_byte(), rand_byte());
                    endcase
            end
            else if (kind <= 7)
            begin
                // transmit flood, oldest byte dropped when full, then takes
                send_item(OP_WRITE, OFS_LCR, rand_byte() & 8'h7F, rand_byte());
                run_len = $urandom_range(4, 24);
                for (k = 0; k < run_len; k++)
                    send_item(OP_WRITE, OFS_DATA, rand_byte(), rand_byte());
                run_len = $urandom_range(1, 24);
                for (k = 0; k < run_len; k++)
                    if ($urandom_range(0, 4) == 0)
                        send_item(OP_READ, OFS_LSR, rand_byte(), rand_byte());
                    else
                        send_item(OP_TX_TAKE, rand_ofs(), rand_byte(), rand_byte());
            end
            else if (kind == 8)
            begin
                // register setup, divisor access, read back
                send_item(OP_WRITE, OFS_IER, rand_byte(), rand_byte());
                send_item(OP_WRITE, OFS_MCR, rand_byte(), rand_byte());
                send_item(OP_WRITE, OFS_SCR, rand_byte(), rand_byte());
                send_item(OP_WRITE, OFS_LCR, rand_byte() | 8'h80, rand_byte());
                send_item(OP_WRITE, OFS_DATA, rand_byte(), rand_byte());
                send_item(OP_WRITE, OFS_IER, rand_byte(), rand_byte());
                for (k = 0; k < 8; k++)
                    send_item(OP_READ, k[2:0], rand_byte(), rand_byte());
                send_item(OP_WRITE, OFS_LCR, rand_byte(), rand_byte());
            end
            else
            begin
                // FIFO resets around a little traffic
                send_item(OP_LINE_RX, OFS_DATA, rand_byte(), rand_byte());
                send_item(OP_WRITE, OFS_DATA, rand_byte(), rand_byte());
                send_item(OP_WRITE, OFS_FCR, rand_byte(), rand_byte());
                send_item(OP_READ, OFS_LSR, rand_byte(), rand_byte());
                send_item(OP_READ, OFS_FCR, rand_byte(), rand_byte());
            end
        end
        in_valid <= 1'b0;
        no_idle  <= 1'b0;

        // Drain, then verdict
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
